// ===== sv/fet_pkg.sv =====
`default_nettype none

package fet_pkg;

    // Default build parameters.
    localparam int TERM_COUNT_DEFAULT      = 4;
    localparam int SINE_TABLE_BITS_DEFAULT = 10;

    // Number of term registers in the register map.
    localparam int TERM_REGS = 4;

    // Configuration port widths.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 40;

    // Field widths.
    localparam int PHASE_W = 16;
    localparam int MAG_W   = 16;
    localparam int HARM_W  = 8;
    localparam int RATE_W  = 16;
    localparam int COUNT_W = 3;
    localparam int POS_W   = 19;
    localparam int VEL_W   = 36;

    // Per-term product widths: magnitude times sinusoid, and
    // magnitude times harmonic times rate times sinusoid.
    localparam int PROD_POS_W = 34;
    localparam int PROD_VEL_W = 57;
    localparam int K_W        = 40;

    // Saturation limits of the result fields.
    localparam longint POS_MAX = 64'sd262143;
    localparam longint POS_MIN = -64'sd262144;
    localparam longint VEL_MAX = 64'sd34359738367;
    localparam longint VEL_MIN = -64'sd34359738368;

    // Quarter turn in Q30 radians.
    localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;

    // Register map.
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_TERM_ZERO    = 3'd0,
        CFG_TERM_ONE     = 3'd1,
        CFG_TERM_TWO     = 3'd2,
        CFG_TERM_THREE   = 3'd3,
        CFG_ACTIVE_TERMS = 3'd4,
        CFG_ANGULAR_RATE = 3'd5
    } t_cfg_index;

    // One packed term register: harmonic, phase offset, magnitude.
    typedef struct packed {
        logic signed [HARM_W-1:0] harm;
        logic [PHASE_W-1:0]       phase;
        logic [MAG_W-1:0]         mag;
    } t_term;

    // Products that one term lane hands to the summing stage.
    typedef struct packed {
        logic signed [PROD_POS_W-1:0] pos_x;
        logic signed [PROD_POS_W-1:0] pos_y;
        logic signed [PROD_VEL_W-1:0] vel_x;
        logic signed [PROD_VEL_W-1:0] vel_y;
    } t_lane_prod;

    // Unsigned floor quotient by restoring long division, one bit per step.
    function automatic logic [63:0] div_floor(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] quo;
        logic [64:0] rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // One quarter-wave table entry in Q15, from a truncated Taylor series
    // of the Q30 angle. Only evaluated while the table is built.
    function automatic logic [15:0] sine_entry(input int unsigned k, input int unsigned bits);
        logic [63:0]        x;
        logic [63:0]        term;
        logic [63:0]        div;
        logic signed [63:0] sum;
        int                 n;
        x    = (64'(k) * 64'(HALF_PI_Q30)) >> bits;
        term = x;
        sum  = $signed(x);
        for (n = 1; n <= 6; n++) begin
            term = (((term * x) >> 30) * x) >> 30;
            div  = 64'((2 * n) * (2 * n + 1));
            term = div_floor(term, div);
            if (n[0]) begin
                sum = sum - $signed(term);
            end else begin
                sum = sum + $signed(term);
            end
        end
        if (sum < 0) begin
            sum = '0;
        end
        sum = (sum + 64'sd16384) >>> 15;
        if (sum > 64'sd32768) begin
            sum = 64'sd32768;
        end
        return sum[15:0];
    endfunction

endpackage

`default_nettype wire

// ===== sv/fet_lane.sv =====
`default_nettype none

module fet_lane #(
    parameter int SINE_TABLE_BITS = fet_pkg::SINE_TABLE_BITS_DEFAULT
) (
    input  wire logic                          i_clk,
    input  wire logic [fet_pkg::PHASE_W-1:0]   i_time_phase,
    input  wire fet_pkg::t_term                i_term,
    input  wire logic [fet_pkg::RATE_W-1:0]    i_rate,
    output fet_pkg::t_lane_prod                o_prod
);
    import fet_pkg::*;

    localparam int ROM_DEPTH = (1 << SINE_TABLE_BITS) + 1;
    localparam int AW        = SINE_TABLE_BITS + 1;
    localparam logic [AW-1:0] FULL_IDX = AW'(1) << SINE_TABLE_BITS;

    typedef logic [15:0] t_rom_arr [ROM_DEPTH];

    // Quarter-wave sine table, built at elaboration.
    function automatic t_rom_arr build_rom();
        t_rom_arr rom;
        for (int k = 0; k < ROM_DEPTH; k++) begin
            rom[k] = sine_entry(k, SINE_TABLE_BITS);
        end
        return rom;
    endfunction

    localparam t_rom_arr SINE_ROM = build_rom();

    // Table address of an angle: mirrored in the second and fourth quadrants.
    function automatic logic [AW-1:0] rom_addr(input logic [PHASE_W-1:0] angle);
        logic [AW-1:0] frac;
        frac = {1'b0, angle[13 -: SINE_TABLE_BITS]};
        return angle[14] ? (FULL_IDX - frac) : frac;
    endfunction

    logic [PHASE_W-1:0]          r_theta;
    logic signed [MAG_W+HARM_W:0] r_mh;
    logic [15:0]                 r_sin_rom;
    logic [15:0]                 r_cos_rom;
    logic                        r_sin_neg;
    logic                        r_cos_neg;
    logic signed [K_W-1:0]       r_k;
    logic [PHASE_W-1:0]          n_theta_c;
    logic signed [16:0]          n_sin;
    logic signed [16:0]          n_cos;

    // Stage one: term angle and magnitude times harmonic.
    always_ff @(posedge i_clk) begin
        r_theta <= PHASE_W'({{(PHASE_W-HARM_W){i_term.harm[HARM_W-1]}}, i_term.harm}
                            * i_time_phase) + i_term.phase;
        r_mh    <= $signed({1'b0, i_term.mag}) * i_term.harm;
    end

    // Stage two: table reads for sine and cosine, and the velocity gain.
    assign n_theta_c = r_theta + PHASE_W'(16'h4000);

    always_ff @(posedge i_clk) begin
        r_sin_rom <= SINE_ROM[rom_addr(r_theta)];
        r_cos_rom <= SINE_ROM[rom_addr(n_theta_c)];
        r_sin_neg <= r_theta[15];
        r_cos_neg <= n_theta_c[15];
        r_k       <= K_W'(r_mh) * K_W'($signed({1'b0, i_rate}));
    end

    // Stage three: signed sinusoids and the four term products.
    assign n_sin = r_sin_neg ? -$signed({1'b0, r_sin_rom}) : $signed({1'b0, r_sin_rom});
    assign n_cos = r_cos_neg ? -$signed({1'b0, r_cos_rom}) : $signed({1'b0, r_cos_rom});

    always_ff @(posedge i_clk) begin
        o_prod.pos_x <= $signed({1'b0, i_term.mag}) * n_cos;
        o_prod.pos_y <= $signed({1'b0, i_term.mag}) * n_sin;
        o_prod.vel_x <= r_k * n_sin;
        o_prod.vel_y <= r_k * n_cos;
    end

endmodule

`default_nettype wire

// ===== sv/fourier_epicycle_trajectory_core.sv =====
`default_nettype none

// Epicycle trajectory point generator.
// An input transfer takes place at a rising edge where start is high and busy
// is low; i_time_phase is the time as a fraction of the base period in 1/65536
// turn. Each transfer yields one result: position o_pos_x/o_pos_y and velocity
// o_vel_x/o_vel_y, shown for exactly one cycle with o_valid high.
// Throughput is one item per clock. Results come out in the order in which
// the items were transferred. The pipeline registers are the input register, the
// term angle multiply, the registered quarter-wave table read, the term
// product multiply (40 by 17 bits), the sum over terms and the rounding and
// saturation register. Every term has its own lane with its own table.
// The receiver cannot stall, so results simply leave one per cycle.
// Configuration is written through i_cfg_we, i_cfg_index and i_cfg_data with
// no wait; it must only change while no item is in flight.
// Synchronous reset clears the configuration and valid registers and empties the
// pipeline; busy is high during reset and low from the first cycle after it.
module fourier_epicycle_trajectory_core #(
    parameter int TERM_COUNT      = fet_pkg::TERM_COUNT_DEFAULT,
    parameter int SINE_TABLE_BITS = fet_pkg::SINE_TABLE_BITS_DEFAULT
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic [fet_pkg::PHASE_W-1:0]         i_time_phase,
    input  wire logic                                i_cfg_we,
    input  wire logic [fet_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  wire logic [fet_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    output logic                                     o_valid,
    output logic signed [fet_pkg::POS_W-1:0]         o_pos_x,
    output logic signed [fet_pkg::POS_W-1:0]         o_pos_y,
    output logic signed [fet_pkg::VEL_W-1:0]         o_vel_x,
    output logic signed [fet_pkg::VEL_W-1:0]         o_vel_y
);
    import fet_pkg::*;

    localparam int LANES = (TERM_COUNT < TERM_REGS) ? TERM_COUNT : TERM_REGS;
    localparam int PSW   = PROD_POS_W + $clog2(LANES) + 1;
    localparam int VSW   = PROD_VEL_W + $clog2(LANES) + 2;

    localparam logic signed [PSW-1:0] P_HALF = PSW'(1) <<< 14;
    localparam logic signed [VSW-1:0] V_HALF = VSW'(1) <<< 22;
    localparam logic signed [PSW-1:0] P_MAX  = PSW'(POS_MAX);
    localparam logic signed [PSW-1:0] P_MIN  = PSW'(POS_MIN);
    localparam logic signed [VSW-1:0] V_MAX  = VSW'(VEL_MAX);
    localparam logic signed [VSW-1:0] V_MIN  = VSW'(VEL_MIN);

    t_term                  r_term [TERM_REGS];
    logic [COUNT_W-1:0]     r_active;
    logic [RATE_W-1:0]      r_rate;
    logic                   r_busy;
    logic [4:0]             r_vld;
    logic [PHASE_W-1:0]     r_phase;
    t_lane_prod             w_prod [LANES];
    logic signed [PSW-1:0]  r_sum_px;
    logic signed [PSW-1:0]  r_sum_py;
    logic signed [VSW-1:0]  r_sum_vx;
    logic signed [VSW-1:0]  r_sum_vy;
    logic signed [PSW-1:0]  n_sum_px;
    logic signed [PSW-1:0]  n_sum_py;
    logic signed [VSW-1:0]  n_sum_vx;
    logic signed [VSW-1:0]  n_sum_vy;
    logic signed [PSW-1:0]  n_px_rnd;
    logic signed [PSW-1:0]  n_py_rnd;
    logic signed [VSW-1:0]  n_vx_rnd;
    logic signed [VSW-1:0]  n_vy_rnd;
    logic signed [POS_W-1:0] n_pos_x;
    logic signed [POS_W-1:0] n_pos_y;
    logic signed [VEL_W-1:0] n_vel_x;
    logic signed [VEL_W-1:0] n_vel_y;
    logic                   r_out_vld;
    logic signed [POS_W-1:0] r_pos_x;
    logic signed [POS_W-1:0] r_pos_y;
    logic signed [VEL_W-1:0] r_vel_x;
    logic signed [VEL_W-1:0] r_vel_y;

    // Register writes; indexes beyond the map are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TERM_REGS; i++) begin
                r_term[i] <= '0;
            end
            r_active <= '0;
            r_rate   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_TERM_ZERO:    r_term[0] <= t_term'(i_cfg_data);
                CFG_TERM_ONE:     r_term[1] <= t_term'(i_cfg_data);
                CFG_TERM_TWO:     r_term[2] <= t_term'(i_cfg_data);
                CFG_TERM_THREE:   r_term[3] <= t_term'(i_cfg_data);
                CFG_ACTIVE_TERMS: r_active  <= i_cfg_data[COUNT_W-1:0];
                CFG_ANGULAR_RATE: r_rate    <= i_cfg_data[RATE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Busy only marks reset; the pipeline takes one item every cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    assign busy = r_busy;

    // Valid bits that travel alongside the data stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_vld     <= {r_vld[3:0], start && !r_busy};
            r_out_vld <= r_vld[4];
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        r_phase <= i_time_phase;
    end

    // One lane per term.
    for (genvar g = 0; g < LANES; g++) begin : g_lane
        fet_lane #(
            .SINE_TABLE_BITS(SINE_TABLE_BITS)
        ) u_lane (
            .i_clk       (i_clk),
            .i_time_phase(r_phase),
            .i_term      (r_term[g]),
            .i_rate      (r_rate),
            .o_prod      (w_prod[g])
        );
    end

    // Sum of the active terms, lowest indexes first.
    always_comb begin
        n_sum_px = '0;
        n_sum_py = '0;
        n_sum_vx = '0;
        n_sum_vy = '0;
        for (int i = 0; i < LANES; i++) begin
            if (COUNT_W'(i) < r_active) begin
                n_sum_px = n_sum_px + PSW'(w_prod[i].pos_x);
                n_sum_py = n_sum_py + PSW'(w_prod[i].pos_y);
                n_sum_vx = n_sum_vx + VSW'(w_prod[i].vel_x);
                n_sum_vy = n_sum_vy + VSW'(w_prod[i].vel_y);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum_px <= n_sum_px;
        r_sum_py <= n_sum_py;
        r_sum_vx <= n_sum_vx;
        r_sum_vy <= n_sum_vy;
    end

    // Round half up, then saturate to the field ranges. The x velocity
    // is the negated sine sum.
    always_comb begin
        n_px_rnd = (r_sum_px + P_HALF) >>> 15;
        n_py_rnd = (r_sum_py + P_HALF) >>> 15;
        n_vx_rnd = ((-r_sum_vx) + V_HALF) >>> 23;
        n_vy_rnd = (r_sum_vy + V_HALF) >>> 23;

        if (n_px_rnd > P_MAX) begin
            n_pos_x = POS_W'(P_MAX);
        end else if (n_px_rnd < P_MIN) begin
            n_pos_x = POS_W'(P_MIN);
        end else begin
            n_pos_x = n_px_rnd[POS_W-1:0];
        end

        if (n_py_rnd > P_MAX) begin
            n_pos_y = POS_W'(P_MAX);
        end else if (n_py_rnd < P_MIN) begin
            n_pos_y = POS_W'(P_MIN);
        end else begin
            n_pos_y = n_py_rnd[POS_W-1:0];
        end

        if (n_vx_rnd > V_MAX) begin
            n_vel_x = VEL_W'(V_MAX);
        end else if (n_vx_rnd < V_MIN) begin
            n_vel_x = VEL_W'(V_MIN);
        end else begin
            n_vel_x = n_vx_rnd[VEL_W-1:0];
        end

        if (n_vy_rnd > V_MAX) begin
            n_vel_y = VEL_W'(V_MAX);
        end else if (n_vy_rnd < V_MIN) begin
            n_vel_y = VEL_W'(V_MIN);
        end else begin
            n_vel_y = n_vy_rnd[VEL_W-1:0];
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        r_pos_x <= n_pos_x;
        r_pos_y <= n_pos_y;
        r_vel_x <= n_vel_x;
        r_vel_y <= n_vel_y;
    end

    assign o_valid = r_out_vld;
    assign o_pos_x = r_pos_x;
    assign o_pos_y = r_pos_y;
    assign o_vel_x = r_vel_x;
    assign o_vel_y = r_vel_y;

    // Every input transfer yields a result strobe.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##6 o_valid)
        else $error("result strobe missing six cycles after an input transfer");

    // No result without a matching input transfer.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, 6))
        else $error("result strobe without an input transfer");

    // With no active terms every field is zero.
    a_no_terms_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $past(r_active, 2) == '0) |->
            (o_pos_x == '0 && o_pos_y == '0 && o_vel_x == '0 && o_vel_y == '0))
        else $error("nonzero result with no active terms");

    // With a zero angular rate the velocity is zero.
    a_zero_rate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $past(r_rate, 4) == '0) |-> (o_vel_x == '0 && o_vel_y == '0))
        else $error("nonzero velocity with zero angular rate");

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`default_nettype none

module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    // Timing of the run.
    localparam int  HALF_PERIOD  = 4;
    localparam int  RESET_CYCLES = 12;
    localparam int  PIPE_LATENCY = 6;
    localparam int  SETTLE_CYCLES = PIPE_LATENCY + 4;
    localparam int  CYCLE_LIMIT  = 200000;

    // Build of the block under test and the size of its sine table.
    localparam int  TERM_LIMIT  = (fet_pkg::TERM_COUNT_DEFAULT < fet_pkg::TERM_REGS) ?
                                  fet_pkg::TERM_COUNT_DEFAULT : fet_pkg::TERM_REGS;
    localparam int  TABLE_BITS  = fet_pkg::SINE_TABLE_BITS_DEFAULT;
    localparam int  TABLE_TOP   = 1 << TABLE_BITS;

    // Register indexes past the end of the register map.
    localparam logic [fet_pkg::CFG_INDEX_W-1:0] CFG_SPARE_SIX   = 3'd6;
    localparam logic [fet_pkg::CFG_INDEX_W-1:0] CFG_SPARE_SEVEN = 3'd7;

    // Angle codes at the quadrant boundaries.
    localparam logic [15:0] TURN_QUARTER       = 16'h4000;
    localparam logic [15:0] TURN_HALF          = 16'h8000;
    localparam logic [15:0] TURN_THREE_QUARTER = 16'hC000;
    localparam logic [15:0] TURN_LAST          = 16'hFFFF;

    // Harmonic extremes.
    localparam logic signed [7:0] HARM_MAX = 8'sd127;
    localparam logic signed [7:0] HARM_MIN = -8'sd128;

    // Saturation limits of the result fields.
    localparam longint POS_HI = 64'sd262143;
    localparam longint POS_LO = -64'sd262144;
    localparam longint VEL_HI = 64'sd34359738367;
    localparam longint VEL_LO = -64'sd34359738368;

    // One expected trajectory point.
    typedef struct {
        logic signed [fet_pkg::POS_W-1:0] pos_x;
        logic signed [fet_pkg::POS_W-1:0] pos_y;
        logic signed [fet_pkg::VEL_W-1:0] vel_x;
        logic signed [fet_pkg::VEL_W-1:0] vel_y;
    } t_trajectory_point;

    logic                               i_clk;
    logic                               i_rst_n;
    logic                               start;
    logic                               busy;
    logic [fet_pkg::PHASE_W-1:0]        i_time_phase;
    logic                               i_cfg_we;
    logic [fet_pkg::CFG_INDEX_W-1:0]    i_cfg_index;
    logic [fet_pkg::CFG_DATA_W-1:0]     i_cfg_data;
    logic                               o_valid;
    logic signed [fet_pkg::POS_W-1:0]   o_pos_x;
    logic signed [fet_pkg::POS_W-1:0]   o_pos_y;
    logic signed [fet_pkg::VEL_W-1:0]   o_vel_x;
    logic signed [fet_pkg::VEL_W-1:0]   o_vel_y;

    // Shadow copy of the configuration registers.
    logic [39:0]                        term_word [fet_pkg::TERM_REGS];
    logic [2:0]                         active_count;
    logic [15:0]                        rate_word;

    longint                             quarter_sine [0:TABLE_TOP];
    t_trajectory_point                  pending_points [$];
    int                                 error_count;
    int                                 cycle_count;
    int                                 gap_percent;

    fourier_epicycle_trajectory_core u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_time_phase (i_time_phase),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_valid      (o_valid),
        .o_pos_x      (o_pos_x),
        .o_pos_y      (o_pos_y),
        .o_vel_x      (o_vel_x),
        .o_vel_y      (o_vel_y)
    );

    // Free-running clock.
    initial i_clk = 1'b0;
    always #(HALF_PERIOD) i_clk = ~i_clk;

    // Quarter-wave entry: Taylor series of the Q30 angle, rounded to Q15.
    function automatic longint taylor_sine(input int unsigned k);
        longint unsigned x;
        longint unsigned term;
        longint          sum;
        x    = (longint'(k) * 64'd1686629713) >> TABLE_BITS;
        term = x;
        sum  = longint'(x);
        for (int n = 1; n <= 6; n++) begin
            term = (((term * x) >> 30) * x) >> 30;
            term = term / longint'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        sum = (sum + 64'sd16384) >>> 15;
        if (sum > 64'sd32768) begin
            sum = 64'sd32768;
        end
        return sum;
    endfunction

    // Signed Q15 sine of an angle in 1/65536 turn.
    function automatic longint sine_of_turn(input logic [15:0] angle);
        logic [1:0] quad;
        int         idx;
        longint     v;
        quad = angle[15:14];
        idx  = int'(angle[13:0]) >> (14 - TABLE_BITS);
        if (quad[0]) begin
            idx = TABLE_TOP - idx;
        end
        v = quarter_sine[idx];
        return quad[1] ? -v : v;
    endfunction

    // Add half an LSB and shift right, rounding toward minus infinity.
    function automatic longint round_half_up(input longint v, input int sh);
        return (v + (longint'(1) <<< (sh - 1))) >>> sh;
    endfunction

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Expected position and velocity for one time phase under the current setting.
    function automatic t_trajectory_point predict_point(input logic [15:0] t);
        t_trajectory_point r;
        longint            px;
        longint            py;
        longint            sx;
        longint            sy;
        longint            mag;
        longint            harm;
        longint            gain;
        longint            s;
        longint            c;
        logic [15:0]       theta;
        int                n_terms;
        px = 0;
        py = 0;
        sx = 0;
        sy = 0;
        n_terms = (int'(active_count) > TERM_LIMIT) ? TERM_LIMIT : int'(active_count);
        for (int i = 0; i < n_terms; i++) begin
            mag   = longint'(term_word[i][15:0]);
            harm  = longint'($signed(term_word[i][39:32]));
            theta = 16'(harm * longint'(t) + longint'(term_word[i][31:16]));
            s     = sine_of_turn(theta);
            c     = sine_of_turn(theta + TURN_QUARTER);
            gain  = mag * harm * longint'(rate_word);
            px    = px + mag * c;
            py    = py + mag * s;
            sx    = sx + gain * s;
            sy    = sy + gain * c;
        end
        r.pos_x = fet_pkg::POS_W'(clamp(round_half_up(px, 15), POS_LO, POS_HI));
        r.pos_y = fet_pkg::POS_W'(clamp(round_half_up(py, 15), POS_LO, POS_HI));
        r.vel_x = fet_pkg::VEL_W'(clamp(round_half_up(-sx, 23), VEL_LO, VEL_HI));
        r.vel_y = fet_pkg::VEL_W'(clamp(round_half_up(sy, 23), VEL_LO, VEL_HI));
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        error_count++;
    endtask

    // Check every result against the oldest pending point.
    always @(posedge i_clk) begin
        t_trajectory_point want;
        if (i_rst_n && o_valid) begin
            if (pending_points.size() == 0) begin
                report_mismatch("result with no pending item", 0, 0);
            end else begin
                want = pending_points.pop_front();
                if (o_pos_x !== want.pos_x) report_mismatch("pos_x", o_pos_x, want.pos_x);
                if (o_pos_y !== want.pos_y) report_mismatch("pos_y", o_pos_y, want.pos_y);
                if (o_vel_x !== want.vel_x) report_mismatch("vel_x", o_vel_x, want.vel_x);
                if (o_vel_y !== want.vel_y) report_mismatch("vel_y", o_vel_y, want.vel_y);
            end
        end
    end

    // Watchdog on the length of the run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("fourier_epicycle_trajectory_core test failed");
            $finish;
        end
    end

    // Write one register and mirror it in the shadow copy; the block is idle here.
    task automatic write_reg(input logic [2:0] idx, input logic [39:0] data);
        if (idx < fet_pkg::TERM_REGS) begin
            term_word[idx[1:0]] = data;
        end else if (idx == fet_pkg::CFG_ACTIVE_TERMS) begin
            active_count = data[2:0];
        end else if (idx == fet_pkg::CFG_ANGULAR_RATE) begin
            rate_word = data[15:0];
        end
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        @(negedge i_clk);
    endtask

    // Send one time phase; returns at the falling edge after the transfer.
    task automatic send_phase(input logic [15:0] ph);
        while ($urandom_range(0, 99) < gap_percent) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start        <= 1'b1;
        i_time_phase <= ph;
        do begin
            @(posedge i_clk);
        end while (busy !== 1'b0);
        pending_points = {pending_points, predict_point(ph)};
        @(negedge i_clk);
    endtask

    // Stop sending and let every pending result come out.
    task automatic quiesce();
        start <= 1'b0;
        while (pending_points.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Writes every term register with one term value.
    task automatic write_all_terms(input logic [39:0] word);
        for (int i = 0; i < fet_pkg::TERM_REGS; i++) begin
            write_reg(3'(fet_pkg::CFG_TERM_ZERO + i), word);
        end
    endtask

    // No active terms after reset: every field is zero.
    task automatic test_no_terms();
        send_phase(16'h0000);
        send_phase(TURN_LAST);
        quiesce();
    endtask

    // One full-size term, swept over the quadrant boundaries and the phase extremes.
    task automatic test_quadrants();
        write_reg(fet_pkg::CFG_TERM_ZERO, fet_pkg::t_term'{8'sd1, 16'h0000, 16'hFFFF});
        write_reg(fet_pkg::CFG_ACTIVE_TERMS, 40'd1);
        write_reg(fet_pkg::CFG_ANGULAR_RATE, 40'h0_0000_FFFF);
        send_phase(16'h0000);
        send_phase(TURN_QUARTER);
        send_phase(TURN_HALF);
        send_phase(TURN_THREE_QUARTER);
        send_phase(TURN_LAST);
        send_phase(16'h0001);
        quiesce();
    endtask

    // Largest positive and negative harmonic with a phase offset.
    task automatic test_harmonic_extremes();
        write_reg(fet_pkg::CFG_TERM_ZERO, fet_pkg::t_term'{HARM_MAX, TURN_LAST, 16'hFFFF});
        write_reg(fet_pkg::CFG_TERM_ONE, fet_pkg::t_term'{HARM_MIN, 16'h1234, 16'h8000});
        write_reg(fet_pkg::CFG_ACTIVE_TERMS, 40'd2);
        send_phase(16'h0155);
        send_phase(TURN_LAST);
        send_phase(16'h7FFF);
        quiesce();
    endtask

    // Zero harmonic: a fixed offset with no velocity.
    task automatic test_zero_harmonic();
        write_reg(fet_pkg::CFG_TERM_ZERO, fet_pkg::t_term'{8'sd0, 16'h2000, 16'hFFFF});
        write_reg(fet_pkg::CFG_ACTIVE_TERMS, 40'd1);
        send_phase(16'h0000);
        send_phase(16'hABCD);
        quiesce();
    endtask

    // Term count above the limit, with all terms aligned so their velocities add.
    task automatic test_term_count_limit();
        write_all_terms(fet_pkg::t_term'{HARM_MIN, 16'h0000, 16'hFFFF});
        write_reg(fet_pkg::CFG_ANGULAR_RATE, 40'h0_0000_FFFF);
        write_reg(fet_pkg::CFG_ACTIVE_TERMS, 40'd7);
        send_phase(TURN_QUARTER);
        send_phase(TURN_THREE_QUARTER);
        quiesce();
        write_reg(fet_pkg::CFG_ACTIVE_TERMS, 40'd5);
        send_phase(16'h0000);
        send_phase(TURN_HALF);
        quiesce();
    endtask

    // Writes to indexes past the register map change nothing.
    task automatic test_unused_index();
        write_reg(CFG_SPARE_SIX, {$urandom(), 8'($urandom())});
        write_reg(CFG_SPARE_SEVEN, 40'hFF_FFFF_FFFF);
        send_phase(16'h1111);
        send_phase(16'hEEEE);
        quiesce();
    endtask

    // A term word, often built from field extremes.
    function automatic logic [39:0] pick_term();
        logic [15:0]       mag;
        logic [15:0]       ph;
        logic signed [7:0] harm;
        if ($urandom_range(0, 3) == 0) begin
            return {8'($urandom()), $urandom()};
        end
        case ($urandom_range(0, 3))
            0:       mag = 16'h0000;
            1:       mag = 16'hFFFF;
            default: mag = 16'($urandom());
        endcase
        ph = ($urandom_range(0, 4) == 0) ? TURN_LAST : 16'($urandom());
        case ($urandom_range(0, 6))
            0:       harm = 8'sd0;
            1:       harm = 8'sd1;
            2:       harm = -8'sd1;
            3:       harm = HARM_MAX;
            4:       harm = HARM_MIN;
            default: harm = 8'($urandom());
        endcase
        return fet_pkg::t_term'{harm, ph, mag};
    endfunction

    // Random settings, each followed by a burst of random time phases.
    task automatic test_random_settings();
        logic [15:0] ph;
        logic [2:0]  count;
        logic [15:0] rate;
        for (int p = 0; p < 8; p++) begin
            for (int i = 0; i < fet_pkg::TERM_REGS; i++) begin
                write_reg(3'(fet_pkg::CFG_TERM_ZERO + i), pick_term());
            end
            case (p)
                0:       count = 3'd4;
                1:       count = 3'd7;
                2:       count = 3'd0;
                default: count = 3'($urandom_range(1, 7));
            endcase
            case (p)
                0:       rate = 16'hFFFF;
                3:       rate = 16'h0000;
                default: rate = 16'($urandom());
            endcase
            write_reg(fet_pkg::CFG_ACTIVE_TERMS, {37'($urandom()), count});
            write_reg(fet_pkg::CFG_ANGULAR_RATE, {24'($urandom()), rate});
            // One setting runs back to back with no gaps at all.
            gap_percent = (p == 5) ? 0 : 28;
            for (int n = 0; n < 48; n++) begin
                case ($urandom_range(0, 15))
                    0:       ph = 16'h0000;
                    1:       ph = TURN_LAST;
                    2:       ph = TURN_QUARTER * 16'($urandom_range(0, 3));
                    default: ph = 16'($urandom());
                endcase
                send_phase(ph);
            end
            quiesce();
        end
    endtask

    initial begin
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_time_phase = '0;
        i_cfg_we     = 1'b0;
        i_cfg_index  = '0;
        i_cfg_data   = '0;
        error_count  = 0;
        cycle_count  = 0;
        gap_percent  = 28;
        for (int i = 0; i < fet_pkg::TERM_REGS; i++) begin
            term_word[i] = '0;
        end
        active_count = '0;
        rate_word    = '0;
        for (int k = 0; k <= TABLE_TOP; k++) begin
            quarter_sine[k] = taylor_sine(k);
        end

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_no_terms();
        test_quadrants();
        test_harmonic_extremes();
        test_zero_harmonic();
        test_term_count_limit();
        test_unused_index();
        test_random_settings();

        if (error_count == 0) begin
            $display("fourier_epicycle_trajectory_core test passed");
        end else begin
            $display("fourier_epicycle_trajectory_core test failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== fourier_epicycle_trajectory_core.f =====
sv/fet_pkg.sv
sv/fet_lane.sv
sv/fourier_epicycle_trajectory_core.sv
tb/sv/tb_top.sv
